// ===== rtl/acfp_pkg.sv =====
// ----------------------------------------------------------------------------
// acfp_pkg
// shared types, constants and the ascii triple decoder of the frame parser
// ----------------------------------------------------------------------------
package acfp_pkg;

    localparam int DEF_BURST_LEN  = 32;
    localparam int DEF_SLOT_LIMIT = 31;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 16;
    localparam int SLOT_W  = 5;
    localparam int TRIPLE_W = 3 * BYTE_W;

    localparam logic [31:0]       HDR_WORD   = 32'h6162_6364;
    localparam logic [BYTE_W-1:0] TRAIL_E    = 8'h65;
    localparam logic [BYTE_W-1:0] TRAIL_F    = 8'h66;
    localparam logic [COORD_W-1:0] ASCII_ZERO = 16'd48;

    typedef enum logic [2:0] {
        PH_SEARCH_HDR = 3'b001,
        PH_SEARCH_TRL = 3'b010,
        PH_FOUND      = 3'b100
    } t_phase;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] y_value;
        logic [COORD_W-1:0] x_value;
    } t_result;

    // three ascii digits, first in the high byte, no digit check, modulo 2^16
    function automatic logic [COORD_W-1:0] decode_triple(input logic [TRIPLE_W-1:0] triple);
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] o;
        h = COORD_W'(triple[23:16]);
        t = COORD_W'(triple[15:8]);
        o = COORD_W'(triple[7:0]);
        return h * 16'd100 + t * 16'd10 + o - ASCII_ZERO * 16'd111;
    endfunction

endpackage

// ===== rtl/acfp_frame.sv =====
// ----------------------------------------------------------------------------
// acfp_frame
// per-burst header/trailer search, digit capture and slot counter
// ----------------------------------------------------------------------------
module acfp_frame #(
    parameter int BURST_LEN  = acfp_pkg::DEF_BURST_LEN,
    parameter int SLOT_LIMIT = acfp_pkg::DEF_SLOT_LIMIT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [acfp_pkg::BYTE_W-1:0] i_byte,
    input  logic                      i_last,
    output logic                      o_emit,
    output acfp_pkg::t_result         o_result
);
    import acfp_pkg::*;

    localparam int POS_W = $clog2(BURST_LEN + 1);

    logic [31:0]          r_hist,   n_hist;
    logic [POS_W-1:0]     r_pos,    n_pos;
    t_phase               r_phase,  n_phase;
    logic [TRIPLE_W-1:0]  r_xdig,   n_xdig;
    logic [1:0]           r_xcnt,   n_xcnt;
    logic [TRIPLE_W-1:0]  r_ydig,   n_ydig;
    logic [SLOT_W-1:0]    r_slot,   n_slot;

    logic [31:0]          hist;
    logic                 in_window;
    logic [TRIPLE_W-1:0]  xs;
    logic [TRIPLE_W-1:0]  ys;
    logic [SLOT_W:0]      slot_inc;

    assign hist      = {r_hist[23:0], i_byte};
    assign in_window = r_pos < POS_W'(BURST_LEN);
    assign slot_inc  = {1'b0, r_slot} + 1'b1;

    always_comb begin
        n_hist  = r_hist;
        n_pos   = r_pos;
        n_phase = r_phase;
        n_xdig  = r_xdig;
        n_xcnt  = r_xcnt;
        n_ydig  = r_ydig;
        n_slot  = r_slot;
        o_emit  = 1'b0;
        xs      = '0;

        if (in_window) begin
            n_pos  = r_pos + 1'b1;
            n_hist = hist;
            case (r_phase)
                PH_SEARCH_HDR: begin
                    if (hist == HDR_WORD) begin
                        n_phase = PH_SEARCH_TRL;
                    end
                end
                PH_SEARCH_TRL, PH_FOUND: begin
                    // trailer 'e' must not sit inside the header
                    if (r_phase == PH_SEARCH_TRL && i_byte == TRAIL_F &&
                        r_hist[7:0] == TRAIL_E && r_xcnt != 2'd0) begin
                        n_ydig  = r_hist[31:8];
                        n_phase = PH_FOUND;
                    end
                    if (r_xcnt != 2'd3) begin
                        n_xdig = {r_xdig[15:0], i_byte};
                        n_xcnt = r_xcnt + 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_SEARCH_HDR;
                end
            endcase
        end

        // missing x digits read as zero bytes
        case (n_xcnt)
            2'd0:    xs = '0;
            2'd1:    xs = {n_xdig[7:0], 16'h0};
            2'd2:    xs = {n_xdig[15:0], 8'h0};
            default: xs = n_xdig;
        endcase
        ys = n_ydig;

        if (i_last) begin
            if (n_phase == PH_FOUND) begin
                o_emit = 1'b1;
                n_slot = (slot_inc >= (SLOT_W+1)'(SLOT_LIMIT)) ? '0 : slot_inc[SLOT_W-1:0];
            end
            n_hist  = '0;
            n_pos   = '0;
            n_phase = PH_SEARCH_HDR;
            n_xdig  = '0;
            n_xcnt  = '0;
            n_ydig  = '0;
        end

        o_emit = o_emit & i_step;
    end

    assign o_result.x_value = decode_triple(xs);
    assign o_result.y_value = decode_triple(ys);
    assign o_result.slot    = n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_pos   <= '0;
            r_phase <= PH_SEARCH_HDR;
            r_xdig  <= '0;
            r_xcnt  <= '0;
            r_ydig  <= '0;
            r_slot  <= '0;
        end else if (i_step) begin
            r_hist  <= n_hist;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_xdig  <= n_xdig;
            r_xcnt  <= n_xcnt;
            r_ydig  <= n_ydig;
            r_slot  <= n_slot;
        end
    end

endmodule

// ===== rtl/ascii_coordinate_frame_parser.sv =====
// latency: the burst's last byte passes the input register, then its result word is held in the output register
// throughput: one byte word per cycle while the result side keeps up
// the input stalls while the output register holds a word that is not taken
// reset: synchronous active low, clears the burst search and the slot counter to 0
// ----------------------------------------------------------------------------
// ascii_coordinate_frame_parser
// finds "abcd" ... "ef" frames in byte bursts and emits decoded x, y and slot
// ----------------------------------------------------------------------------
module ascii_coordinate_frame_parser #(
    parameter int BURST_LEN  = acfp_pkg::DEF_BURST_LEN,
    parameter int SLOT_LIMIT = acfp_pkg::DEF_SLOT_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tlast,   // burst_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [15:0] x_value, [31:16] y_value, [36:32] slot
);
    import acfp_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              step;
    logic              emit;
    t_result           result;

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || step;

    acfp_frame #(
        .BURST_LEN  (BURST_LEN),
        .SLOT_LIMIT (SLOT_LIMIT)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out};

endmodule

// ===== bench/tb_ascii_coordinate_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tb_ascii_coordinate_frame_parser
// self-checking bench: byte bursts with "abcd" ... "ef" frames go in, every
// decoded x / y / slot word that comes out is compared with a local predictor
// ----------------------------------------------------------------------------
module tb_ascii_coordinate_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import acfp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int BYTE_TARGET = 2000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } t_rx_item;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [4:0]  slot;
    } t_coord;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;    // [7:0] rx_byte
    logic        i_s_tlast = 1'b0;  // burst_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // [15:0] x_value, [31:16] y_value, [36:32] slot

    ascii_coordinate_frame_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // stimulus and expectations
    t_rx_item   rx_pending[$];
    logic [7:0] burst_buf[$];
    t_coord     coords_due[$];

    // predictor state
    logic [31:0] scan_hist;
    int          scan_pos;
    t_phase      scan_phase;
    logic [23:0] x_bytes;
    int          x_count;
    logic [23:0] y_bytes;
    int          slot_now;

    int n_sent;
    int n_bursts;
    int n_frames;
    int n_wraps;
    int n_checked;
    int n_errors;
    int cycle_count;
    int gap_left;
    int stall_left;
    logic rx_hold = 1'b0;
    t_rx_item next_item;

    // quiet windows with no idling on either side
    wire calm = (cycle_count[11:10] == 2'b11);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     coords_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [15:0] triple_to_coord(input logic [23:0] tri3);
        int unsigned v;
        v = 100 * tri3[23:16] + 10 * tri3[15:8] + tri3[7:0] - 111 * 48;
        return v[15:0];
    endfunction

    task automatic clear_scan();
        scan_hist  = '0;
        scan_pos   = 0;
        scan_phase = PH_SEARCH_HDR;
        x_bytes    = '0;
        x_count    = 0;
        y_bytes    = '0;
    endtask

    // advance the frame search by one accepted byte, queue a word at burst end
    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [31:0] prev;
        logic [31:0] hist;
        logic [23:0] xs;
        t_coord      c;
        if (scan_pos < DEF_BURST_LEN) begin
            prev = scan_hist;
            hist = {prev[23:0], b};
            scan_pos++;
            if (scan_phase == PH_SEARCH_HDR) begin
                if (hist == HDR_WORD) scan_phase = PH_SEARCH_TRL;
            end else begin
                if (scan_phase == PH_SEARCH_TRL && b == TRAIL_F && prev[7:0] == TRAIL_E
                    && x_count >= 1) begin
                    y_bytes    = prev[31:8];
                    scan_phase = PH_FOUND;
                end
                if (x_count < 3) begin
                    x_bytes = {x_bytes[15:0], b};
                    x_count++;
                end
            end
            scan_hist = hist;
        end
        if (last) begin
            n_bursts++;
            if (scan_phase == PH_FOUND) begin
                // short x: missing digits read as zero bytes
                xs = x_bytes;
                for (int k = x_count; k < 3; k++) xs = {xs[15:0], 8'h00};
                slot_now++;
                if (slot_now >= DEF_SLOT_LIMIT) begin
                    slot_now = 0;
                    n_wraps++;
                end
                c.x    = triple_to_coord(xs);
                c.y    = triple_to_coord(y_bytes);
                c.slot = slot_now[4:0];
                coords_due.push_back(c);
                n_frames++;
            end
            clear_scan();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got,
                 want);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tlast  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast);
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (rx_pending.size() > 0
                             && !(rx_pending[0].drain && coords_due.size() > 0)) begin
                    next_item = rx_pending.pop_front();
                    i_s_tdata  <= next_item.data;
                    i_s_tlast  <= next_item.last;
                    i_s_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_checked++;
                if (coords_due.size() == 0) begin
                    report_mismatch("unexpected word", int'(o_m_tdata), 0);
                end else begin
                    t_coord want;
                    want = coords_due.pop_front();
                    if (o_m_tdata[15:0] !== want.x)
                        report_mismatch("x_value", int'(o_m_tdata[15:0]), int'(want.x));
                    if (o_m_tdata[31:16] !== want.y)
                        report_mismatch("y_value", int'(o_m_tdata[31:16]), int'(want.y));
                    if (o_m_tdata[36:32] !== want.slot)
                        report_mismatch("slot", int'(o_m_tdata[36:32]), int'(want.slot));
                    if (o_m_tdata[39:37] !== 3'b000)
                        report_mismatch("tdata padding", int'(o_m_tdata[39:37]), 0);
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!calm && $urandom_range(0, 99) < 15)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
            i_m_tready <= !rx_hold && stall_left == 0;
        end
    end

    // long receiver hold-off while the sender keeps going
    initial begin
        wait (n_sent >= 400);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) burst_buf.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            burst_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                            : 8'(48 + $urandom_range(0, 9)));
    endtask

    task automatic put_junk(input int n);
        for (int i = 0; i < n; i++)
            burst_buf.push_back(($urandom_range(0, 9) < 3) ? 8'(8'h61 + $urandom_range(0, 5))
                                                           : 8'($urandom));
    endtask

    // move the collected bytes to the send queue, last one flagged as burst end
    task automatic close_burst(input bit drain, inout int counted);
        t_rx_item it;
        for (int i = 0; i < burst_buf.size(); i++) begin
            it.data  = burst_buf[i];
            it.last  = (i == burst_buf.size() - 1);
            it.drain = drain && i == 0;
            rx_pending.push_back(it);
        end
        counted += (burst_buf.size() < DEF_BURST_LEN) ? burst_buf.size() : DEF_BURST_LEN;
        burst_buf.delete();
    endtask

    task automatic build_random_burst(input int idx, inout int counted);
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            put_junk(($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3));
            put_text("abcd");
            put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                   : $urandom_range(0, 5));
            put_text("ef");
            put_junk($urandom_range(0, 2));
        end else if (kind < 70) begin
            // frame straddling or beyond the burst length limit
            put_junk($urandom_range(22, 34));
            put_text("abcd");
            put_digits($urandom_range(0, 4));
            put_text("ef");
            put_junk($urandom_range(0, 8));
        end else if (kind < 85) begin
            pick = $urandom_range(0, 2);
            put_junk($urandom_range(0, 3));
            if (pick == 0) begin
                put_text("abcd");
                burst_buf[burst_buf.size() - 1 - $urandom_range(0, 3)] = 8'($urandom);
                put_digits(3);
                put_text("ef");
            end else if (pick == 1) begin
                put_text("abcd");
                put_digits($urandom_range(0, 6));
            end else begin
                put_text("abcd");
                put_digits($urandom_range(0, 3));
                put_text("e");
                put_junk($urandom_range(1, 2));
                put_text("f");
            end
        end else begin
            put_junk($urandom_range(1, 40));
        end
        close_burst(idx % 40 == 0, counted);
    endtask

    initial begin
        int counted;
        int idx;
        counted = 0;
        clear_scan();
        slot_now = 0;

        // empty payload and short x at once, then a three-digit frame and one with non-digit bytes
        put_text("abcdef");
        close_burst(1'b0, counted);
        put_text("abcd000ef");
        close_burst(1'b0, counted);
        put_text("abcd");
        repeat (3) burst_buf.push_back(8'hFF);
        put_text("ef");
        close_burst(1'b0, counted);
        // single zero byte, no frame
        burst_buf.push_back(8'h00);
        close_burst(1'b0, counted);

        idx = 0;
        while (counted < BYTE_TARGET) begin
            build_random_burst(idx, counted);
            idx++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (coords_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes in %0d bursts, %0d frames decoded, slot wrapped %0d times",
                 n_sent, n_bursts, n_frames, n_wraps);
        $display("checked %0d result words, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
